>>> hw/rtl/lru_footprint_limit_evictor_defines.svh
// Assertion macros for the evictor checker
`ifndef LRU_FOOTPRINT_LIMIT_EVICTOR_DEFINES_SVH
`define LRU_FOOTPRINT_LIMIT_EVICTOR_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent
`define LRUFL_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent checked in the cycle after the antecedent
`define LRUFL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/lrufl_pkg.sv
// Shared constants, codes and controller/datapath bundles for the LRU footprint evictor
package lrufl_pkg;

  localparam int SLOT_COUNT = 16;
  localparam int FP_W       = 32;
  localparam int FP_PORT_W  = 32;
  localparam int LIMIT_W    = 40;
  localparam int SLOT_W     = 4;
  localparam int STATUS_W   = 2;
  localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
  // one bit of headroom over the wider of limit and footprint
  localparam int TOTAL_W    = ((FP_W > LIMIT_W) ? FP_W : LIMIT_W) + 1;

  localparam logic OP_ACQUIRE = 1'b0;
  localparam logic OP_ACCESS  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE     = 2'd0,
    ST_EVICTED  = 2'd1,
    ST_IGNORED  = 2'd2,
    ST_REJECTED = 2'd3
  } status_t;

  typedef struct packed {
    logic    load;
    logic    rd_en;
    logic    rd_oldest;
    logic    unlink;
    logic    evict;
    logic    push;
    logic    alloc;
    logic    emit;
    status_t emit_status;
    logic    emit_victim;
    logic    emit_last;
  } lrufl_cmd_t;

  typedef struct packed {
    logic op;
    logic slot_ok;
    logic alive;
    logic too_big;
    logic is_newest;
    logic over_limit;
    logic multi;
    logic out_free;
  } lrufl_stat_t;

endpackage

>>> hw/rtl/lrufl_req_if.sv
// Request channel: valid/ready with op, slot and footprint
interface lrufl_req_if import lrufl_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 op;
  logic [SLOT_W-1:0]    slot;
  logic [FP_PORT_W-1:0] footprint;

  modport source (output valid, output op, output slot, output footprint, input ready);
  modport sink   (input valid, input op, input slot, input footprint, output ready);
endinterface

>>> hw/rtl/lrufl_rsp_if.sv
// Result channel: valid/ready with status, slot, running total and last flag
interface lrufl_rsp_if import lrufl_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   result_slot;
  logic [LIMIT_W-1:0]  total_footprint;
  logic                last;

  modport source (output valid, output status, output result_slot, output total_footprint,
                  output last, input ready);
  modport sink   (input valid, input status, input result_slot, input total_footprint,
                  input last, output ready);
endinterface

>>> hw/rtl/lrufl_ctrl.sv
// Sequencer for acquire, access and eviction steps
module lrufl_ctrl import lrufl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  lrufl_stat_t stat,
  output lrufl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_UNLINK,
    S_PUSH,
    S_ALLOC,
    S_EVAL,
    S_EVICT,
    S_EMIT
  } state_t;

  state_t  state;
  status_t em_status;
  logic    em_victim;
  logic    em_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      em_status <= ST_DONE;
      em_victim <= 1'b0;
      em_last   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) state <= S_CHECK;
        end
        S_CHECK: begin
          em_victim <= 1'b0;
          em_last   <= 1'b1;
          if (stat.op == OP_ACCESS) begin
            if (!stat.alive) begin
              em_status <= ST_IGNORED;
              state     <= S_EMIT;
            end else if (stat.is_newest) begin
              // already newest: order does not change
              em_status <= ST_DONE;
              state     <= S_EMIT;
            end else begin
              state <= S_UNLINK;
            end
          end else begin
            if (!stat.slot_ok || stat.too_big || stat.alive) begin
              em_status <= ST_REJECTED;
              state     <= S_EMIT;
            end else begin
              state <= S_ALLOC;
            end
          end
        end
        S_UNLINK: state <= S_PUSH;
        S_PUSH: begin
          em_status <= ST_DONE;
          em_victim <= 1'b0;
          em_last   <= 1'b1;
          state     <= S_EMIT;
        end
        S_ALLOC: state <= S_EVAL;
        S_EVAL: begin
          if (stat.over_limit && stat.multi) begin
            state <= S_EVICT;
          end else begin
            em_status <= ST_DONE;
            em_victim <= 1'b0;
            em_last   <= 1'b1;
            state     <= S_EMIT;
          end
        end
        S_EVICT: begin
          em_status <= ST_EVICTED;
          em_victim <= 1'b1;
          em_last   <= 1'b0;
          state     <= S_EMIT;
        end
        S_EMIT: begin
          if (stat.out_free) state <= em_last ? S_IDLE : S_EVAL;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign req_ready = (state == S_IDLE);

  always_comb begin
    cmd             = '0;
    cmd.emit_status = em_status;
    cmd.emit_victim = em_victim;
    cmd.emit_last   = em_last;
    unique case (state)
      S_IDLE:   cmd.load = req_valid;
      S_CHECK:  cmd.rd_en = 1'b1;
      S_UNLINK: cmd.unlink = 1'b1;
      S_PUSH:   cmd.push = 1'b1;
      S_ALLOC: begin
        cmd.push  = 1'b1;
        cmd.alloc = 1'b1;
      end
      S_EVAL: begin
        cmd.rd_en     = 1'b1;
        cmd.rd_oldest = 1'b1;
      end
      S_EVICT: begin
        cmd.unlink = 1'b1;
        cmd.evict  = 1'b1;
      end
      S_EMIT:   cmd.emit = stat.out_free;
      default:  cmd.emit = 1'b0;
    endcase
  end

endmodule

>>> hw/rtl/lrufl_dp.sv
// Slot table, recency links, running total and result register
module lrufl_dp import lrufl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [LIMIT_W-1:0]   cfg_wr_data,
  input  logic                 req_op,
  input  logic [SLOT_W-1:0]    req_slot,
  input  logic [FP_PORT_W-1:0] req_footprint,
  input  lrufl_cmd_t           cmd,
  output lrufl_stat_t          stat,
  input  logic                 rsp_ready,
  output logic                 rsp_valid,
  output logic [STATUS_W-1:0]  rsp_status,
  output logic [SLOT_W-1:0]    rsp_slot,
  output logic [LIMIT_W-1:0]   rsp_total,
  output logic                 rsp_last
);

  logic [LIMIT_W-1:0] limit;

  logic               r_op;
  logic [SLOT_W-1:0]  r_slot;
  logic [FP_W-1:0]    r_fp;
  logic [IDX_W-1:0]   r_idx;

  logic               alive_bits [SLOT_COUNT];
  logic [FP_W-1:0]    slot_fp    [SLOT_COUNT];
  logic [IDX_W-1:0]   older_link [SLOT_COUNT];
  logic [IDX_W-1:0]   newer_link [SLOT_COUNT];
  logic [IDX_W-1:0]   oldest;
  logic [IDX_W-1:0]   newest;
  logic [CNT_W-1:0]   count;
  logic [TOTAL_W-1:0] total;

  // slot picked by the last read, with its neighbors and footprint
  logic [IDX_W-1:0]   v_idx;
  logic [IDX_W-1:0]   v_older;
  logic [IDX_W-1:0]   v_newer;
  logic [FP_W-1:0]    v_fp;
  logic [IDX_W-1:0]   rd_addr;

  logic               slot_ok;
  logic [LIMIT_W-1:0] total_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= '0;
    end else if (cfg_wr_en) begin
      limit <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_op   <= req_op;
      r_slot <= req_slot;
      r_fp   <= FP_W'(req_footprint);
    end
  end

  assign r_idx   = IDX_W'(r_slot);
  assign slot_ok = (32'(r_slot) < SLOT_COUNT);
  assign rd_addr = cmd.rd_oldest ? oldest : r_idx;

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      v_idx   <= rd_addr;
      v_older <= older_link[rd_addr];
      v_newer <= newer_link[rd_addr];
      v_fp    <= slot_fp[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) alive_bits[i] <= 1'b0;
    end else begin
      if (cmd.alloc) alive_bits[r_idx] <= 1'b1;
      if (cmd.evict) alive_bits[v_idx] <= 1'b0;
    end
  end

  // link and footprint storage, valid only for alive slots
  always_ff @(posedge clk) begin
    if (cmd.unlink) begin
      if (v_idx != oldest) newer_link[v_older] <= v_newer;
      if (v_idx != newest) older_link[v_newer] <= v_older;
    end
    if (cmd.push && (count != '0)) begin
      newer_link[newest] <= r_idx;
      older_link[r_idx]  <= newest;
    end
    if (cmd.alloc) slot_fp[r_idx] <= r_fp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oldest <= '0;
      newest <= '0;
      count  <= '0;
      total  <= '0;
    end else begin
      if (cmd.unlink) begin
        if (v_idx == oldest) oldest <= v_newer;
        if (v_idx == newest) newest <= v_older;
        count <= count - CNT_W'(1);
      end
      if (cmd.push) begin
        if (count == '0) oldest <= r_idx;
        newest <= r_idx;
        count  <= count + CNT_W'(1);
      end
      if (cmd.alloc) total <= total + TOTAL_W'(r_fp);
      if (cmd.evict) total <= total - TOTAL_W'(v_fp);
    end
  end

  assign stat.op         = r_op;
  assign stat.slot_ok    = slot_ok;
  assign stat.alive      = slot_ok && alive_bits[r_idx];
  assign stat.too_big    = (TOTAL_W'(r_fp) >= TOTAL_W'(limit));
  assign stat.is_newest  = (r_idx == newest);
  assign stat.over_limit = (total > TOTAL_W'(limit));
  assign stat.multi      = (count > CNT_W'(1));
  assign stat.out_free   = !rsp_valid || rsp_ready;

  assign total_sat = (|total[TOTAL_W-1:LIMIT_W]) ? '1 : total[LIMIT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rsp_status <= cmd.emit_status;
      rsp_slot   <= cmd.emit_victim ? SLOT_W'(v_idx) : r_slot;
      rsp_total  <= total_sat;
      rsp_last   <= cmd.emit_last;
    end
  end

endmodule

>>> hw/rtl/lru_footprint_limit_evictor.sv
// Top level: LRU slot table that evicts oldest slots to stay within a footprint limit
// Steps, from request transfer: a reject, an ignored access or an access to the newest slot
// goes check, emit; a reordering access check, unlink, push, emit; an acquire check, alloc,
// eval, then per evicted slot evict, emit, eval, and a final emit. One request at a time, by
// the list sequencer (one link update per cycle, held in emit while a result stalls).
// Reset (rst, synchronous): clears alive bits, list ends, total and limit; no clearing pass.
module lru_footprint_limit_evictor import lrufl_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [LIMIT_W-1:0] cfg_wr_data,
  lrufl_req_if.sink          req,
  lrufl_rsp_if.source        rsp
);

  lrufl_cmd_t  cmd;
  lrufl_stat_t stat;

  lrufl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lrufl_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .req_op        (req.op),
    .req_slot      (req.slot),
    .req_footprint (req.footprint),
    .cmd           (cmd),
    .stat          (stat),
    .rsp_ready     (rsp.ready),
    .rsp_valid     (rsp.valid),
    .rsp_status    (rsp.status),
    .rsp_slot      (rsp.result_slot),
    .rsp_total     (rsp.total_footprint),
    .rsp_last      (rsp.last)
  );

endmodule

>>> hw/rtl/lrufl_checker.sv
// Port-level checks for the evictor, attached by bind
`include "lru_footprint_limit_evictor_defines.svh"

module lrufl_checker import lrufl_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input logic [STATUS_W-1:0] rsp_status,
  input logic [SLOT_W-1:0]   rsp_slot,
  input logic [LIMIT_W-1:0]  rsp_total,
  input logic                rsp_last
);

  `LRUFL_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_slot) && $stable(rsp_total) && $stable(rsp_last), "result changed while stalled")
  `LRUFL_ASSERT_NEXT(a_one_at_a_time, clk, rst, req_valid && req_ready, !req_ready, "request taken while busy")
  `LRUFL_ASSERT_SAME(a_final_last, clk, rst, rsp_valid && (rsp_status != ST_EVICTED), rsp_last, "final result without last")
  `LRUFL_ASSERT_SAME(a_evict_not_last, clk, rst, rsp_valid && (rsp_status == ST_EVICTED), !rsp_last, "eviction marked last")

endmodule

bind lru_footprint_limit_evictor lrufl_checker u_lrufl_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_status (rsp.status),
  .rsp_slot   (rsp.result_slot),
  .rsp_total  (rsp.total_footprint),
  .rsp_last   (rsp.last)
);
